### rtl/qrs_pkg.sv
// Shared constants, codes and cell payload types of the quadratic root solver.
package qrs_pkg;

  localparam int FracBits = 16;
  localparam int CoefW    = 16;
  localparam int RootW    = 34;
  localparam int StatW    = 2;

  // Square root: discriminant bit pairs plus one step per fraction bit
  localparam int SqPairs  = 17;
  localparam int DiscW    = 2 * SqPairs;
  localparam int SqSteps  = SqPairs + FracBits;
  localparam int SqW      = SqSteps;
  localparam int SqRemW   = SqW + 2;

  // Numerator, denominator and quotient widths
  localparam int NbW      = CoefW + 1 + FracBits;
  localparam int NumW     = SqW + 1;
  localparam int NW       = NumW + 1;
  localparam int DenW     = CoefW + 1;
  localparam int ResW     = NumW + 1;
  localparam int WideW    = (ResW > RootW) ? ResW : RootW;

  localparam longint NoRootVal = -100 * (longint'(1) << FracBits);
  localparam logic signed [RootW-1:0] NoRoot = RootW'(NoRootVal);
  localparam logic signed [WideW-1:0] RootMax = WideW'((longint'(1) << (RootW - 1)) - 1);
  localparam logic signed [WideW-1:0] RootMin = -RootMax - WideW'(1);

  typedef enum logic [StatW-1:0] {
    StNone   = 2'd0,
    StDouble = 2'd1,
    StTwo    = 2'd2,
    StAZero  = 2'd3
  } status_e;

  // Payload of one square root cell
  typedef struct packed {
    status_e                  status;
    logic signed [NbW-1:0]    nb;
    logic signed [DenW:0]     den;
    logic [SqRemW-1:0]        rem;
    logic [SqW-1:0]           root;
    logic [DiscW-1:0]         d;
  } sq_t;

  // Payload of one divider cell, both roots side by side
  typedef struct packed {
    status_e                  status;
    logic                     neg1;
    logic                     neg2;
    logic [DenW-1:0]          den;
    logic [DenW-1:0]          rem1;
    logic [DenW-1:0]          rem2;
    logic [NumW-1:0]          n1;
    logic [NumW-1:0]          n2;
    logic [NumW-1:0]          q1;
    logic [NumW-1:0]          q2;
  } dv_t;

  // Clamp a wide signed root to the output range
  function automatic logic signed [RootW-1:0] sat_root(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] r;
    r = v;
    if (v > RootMax) r = RootMax;
    if (v < RootMin) r = RootMin;
    return RootW'(r);
  endfunction

endpackage

### rtl/qrs_sqrt_cell.sv
// One restoring square root step: one result bit per cell.
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sq_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output sq_t  out_data_o
);

  logic               valid_q;
  sq_t                data_q;
  sq_t                data_d;
  logic [SqRemW+1:0]  rem_sh;
  logic [SqRemW+1:0]  trial;
  logic               ge;

  // Bring down the next bit pair and try the subtraction
  always_comb begin
    rem_sh = {in_data_i.rem, in_data_i.d[DiscW-1 -: 2]};
    trial  = (SqRemW+2)'({in_data_i.root, 2'b01});
    ge     = (rem_sh >= trial);
    data_d = in_data_i;
    data_d.rem  = SqRemW'(ge ? (rem_sh - trial) : rem_sh);
    data_d.root = {in_data_i.root[SqW-2:0], ge};
    data_d.d    = in_data_i.d << 2;
  end

  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Advance when the neighbor takes the transaction or the cell is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/qrs_div_cell.sv
// One restoring division step for both numerators: one quotient bit per cell.
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  dv_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output dv_t  out_data_o
);

  logic            valid_q;
  dv_t             data_q;
  dv_t             data_d;
  logic [DenW:0]   sh1;
  logic [DenW:0]   sh2;
  logic [DenW:0]   den_x;
  logic            ge1;
  logic            ge2;

  // Shift in the next numerator bit and subtract when it fits
  always_comb begin
    den_x = {1'b0, in_data_i.den};
    sh1   = {in_data_i.rem1, in_data_i.n1[NumW-1]};
    sh2   = {in_data_i.rem2, in_data_i.n2[NumW-1]};
    ge1   = (sh1 >= den_x);
    ge2   = (sh2 >= den_x);
    data_d = in_data_i;
    data_d.rem1 = DenW'(ge1 ? (sh1 - den_x) : sh1);
    data_d.rem2 = DenW'(ge2 ? (sh2 - den_x) : sh2);
    data_d.n1   = in_data_i.n1 << 1;
    data_d.n2   = in_data_i.n2 << 1;
    data_d.q1   = {in_data_i.q1[NumW-2:0], ge1};
    data_d.q2   = {in_data_i.q2[NumW-2:0], ge2};
  end

  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Advance when the neighbor takes the transaction or the cell is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: multiply stage, root and divide cell chains, output.
//
// Takes one coefficient triple per cycle while the output side does not stall and returns one
// result per triple, in order, through one multiply stage, 33 square root cells
// (one root bit each), 34 divider cells (one quotient bit each for both roots at once) and
// the output register. Every cell holds its own transaction, so a stall at the output only
// fills empty cells behind it and the input keeps being taken while any cell is free.
// Roots are signed Q17.16; status 0 no real roots, 1 double root, 2 two roots, 3 a is zero,
// and both roots read -100.0 for status 0 and 3.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // root_first [33:0], root_second [67:34], zeros
  output logic [1:0]  m_axis_tuser_o   // root_status [1:0]
);

  // Multiply stage
  logic                          v1_q;
  logic signed [CoefW-1:0]       a1_q;
  logic signed [CoefW-1:0]       b1_q;
  logic [2*CoefW-1:0]            bb1_q;
  logic signed [2*CoefW-1:0]     ac1_q;
  logic signed [CoefW-1:0]       a_in;
  logic signed [CoefW-1:0]       b_in;
  logic signed [CoefW-1:0]       c_in;
  logic signed [2*CoefW-1:0]     bb_in;

  // Cell chains
  logic sq_vld [SqSteps+1];
  logic sq_rdy [SqSteps+1];
  sq_t  sq_dat [SqSteps+1];
  logic dv_vld [NumW+1];
  logic dv_rdy [NumW+1];
  dv_t  dv_dat [NumW+1];

  // Discriminant and chain entry
  logic signed [DiscW:0]         bb_x;
  logic signed [DiscW:0]         ac_x;
  logic signed [DiscW:0]         dsc;
  status_e                       st_in;

  // Divider entry
  logic signed [NW-1:0]          n1;
  logic signed [NW-1:0]          n2;
  sq_t                           sq_last;

  // Output stage
  logic                          mv_q;
  logic signed [RootW-1:0]       r1_q;
  logic signed [RootW-1:0]       r2_q;
  status_e                       st_q;
  logic signed [ResW-1:0]        res1;
  logic signed [ResW-1:0]        res2;
  logic signed [RootW-1:0]       r1_d;
  logic signed [RootW-1:0]       r2_d;
  dv_t                           dv_last;

  assign a_in  = s_axis_tdata_i[15:0];
  assign b_in  = s_axis_tdata_i[31:16];
  assign c_in  = s_axis_tdata_i[47:32];
  assign bb_in = b_in * b_in;

  assign s_axis_tready_o = ~v1_q | sq_rdy[0];

  // Hold the coefficient products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      a1_q  <= a_in;
      b1_q  <= b_in;
      bb1_q <= bb_in;
      ac1_q <= a_in * c_in;
    end
  end

  // Form the discriminant and classify the triple
  always_comb begin
    bb_x = (DiscW+1)'(signed'({1'b0, bb1_q}));
    ac_x = (DiscW+1)'(ac1_q);
    dsc  = bb_x - (ac_x <<< 2);
    if (a1_q == '0) begin
      st_in = StAZero;
    end else if (dsc < 0) begin
      st_in = StNone;
    end else if (dsc == '0) begin
      st_in = StDouble;
    end else begin
      st_in = StTwo;
    end
    sq_dat[0].status = st_in;
    sq_dat[0].nb     = -(NbW'(b1_q)) <<< FracBits;
    sq_dat[0].den    = (DenW+1)'(a1_q) <<< 1;
    sq_dat[0].rem    = '0;
    sq_dat[0].root   = '0;
    sq_dat[0].d      = (st_in == StTwo) ? DiscW'(dsc) : '0;
  end
  assign sq_vld[0] = v1_q;

  // Square root chain
  for (genvar i = 0; i < SqSteps; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sq_vld[i]),
      .in_ready_o  (sq_rdy[i]),
      .in_data_i   (sq_dat[i]),
      .out_valid_o (sq_vld[i+1]),
      .out_ready_i (sq_rdy[i+1]),
      .out_data_o  (sq_dat[i+1])
    );
  end

  // Form both numerators and split off their signs
  always_comb begin
    sq_last = sq_dat[SqSteps];
    n1 = NW'(sq_last.nb) + NW'(signed'({1'b0, sq_last.root}));
    n2 = NW'(sq_last.nb) - NW'(signed'({1'b0, sq_last.root}));
    dv_dat[0].status = sq_last.status;
    dv_dat[0].neg1   = n1[NW-1] ^ sq_last.den[DenW];
    dv_dat[0].neg2   = n2[NW-1] ^ sq_last.den[DenW];
    dv_dat[0].den    = DenW'(sq_last.den[DenW] ? -sq_last.den : sq_last.den);
    dv_dat[0].rem1   = '0;
    dv_dat[0].rem2   = '0;
    dv_dat[0].n1     = NumW'(n1[NW-1] ? -n1 : n1);
    dv_dat[0].n2     = NumW'(n2[NW-1] ? -n2 : n2);
    dv_dat[0].q1     = '0;
    dv_dat[0].q2     = '0;
  end
  assign dv_vld[0]       = sq_vld[SqSteps];
  assign sq_rdy[SqSteps] = dv_rdy[0];

  // Divider chain
  for (genvar j = 0; j < NumW; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_vld[j]),
      .in_ready_o  (dv_rdy[j]),
      .in_data_i   (dv_dat[j]),
      .out_valid_o (dv_vld[j+1]),
      .out_ready_i (dv_rdy[j+1]),
      .out_data_o  (dv_dat[j+1])
    );
  end

  // Restore signs, clamp and replace roots that do not exist
  always_comb begin
    dv_last = dv_dat[NumW];
    res1 = dv_last.neg1 ? -ResW'(dv_last.q1) : ResW'(dv_last.q1);
    res2 = dv_last.neg2 ? -ResW'(dv_last.q2) : ResW'(dv_last.q2);
    if (dv_last.status == StNone || dv_last.status == StAZero) begin
      r1_d = NoRoot;
      r2_d = NoRoot;
    end else begin
      r1_d = sat_root(WideW'(res1));
      r2_d = sat_root(WideW'(res2));
    end
  end

  assign dv_rdy[NumW] = ~mv_q | m_axis_tready_i;

  // Hold the result until the sink takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (dv_rdy[NumW]) begin
      mv_q <= dv_vld[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_rdy[NumW] && dv_vld[NumW]) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      st_q <= dv_last.status;
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {4'b0000, r2_q, r1_q};
  assign m_axis_tuser_o  = st_q;

endmodule

### tb/quadratic_root_solver_tb.sv
// Self-checking testbench of the quadratic root solver: directed table, then random triples.
`timescale 1ns / 1ps

module quadratic_root_solver_tb
  import qrs_pkg::*;
();

  localparam int NumRandom = 1030;
  localparam int NumRows   = 20;

  typedef struct {
    logic signed [RootW-1:0] first;
    logic signed [RootW-1:0] second;
    status_e                 status;
  } roots_t;

  typedef struct {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    logic                    known;
    roots_t                  res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [47:0] in_data;
  logic        out_valid;
  logic        out_ready;
  logic [71:0] out_data;
  logic [1:0]  out_user;

  roots_t expected_roots[$];
  int     mismatches = 0;
  bit     stim_done;
  bit     long_hold;
  row_t   rows[NumRows];

  quadratic_root_solver dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // Floor of sqrt(d) scaled by 2^FracBits, restoring bit pairs
  function automatic longint fixed_sqrt(input longint d);
    longint root;
    longint rem;
    longint trial;
    longint pair;
    root = 0;
    rem  = 0;
    for (int i = 0; i < SqPairs + FracBits; i++) begin
      pair  = (i < SqPairs) ? ((d >> (2 * (SqPairs - 1 - i))) & 3) : 0;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [RootW-1:0] clamp_root(input longint v);
    longint hi;
    hi = (longint'(1) << (RootW - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return RootW'(v);
  endfunction

  // Expected roots of one coefficient triple
  function automatic roots_t solve_roots(input logic signed [CoefW-1:0] ca,
                                         input logic signed [CoefW-1:0] cb,
                                         input logic signed [CoefW-1:0] cc);
    roots_t r;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint den;
    longint nb;
    longint s;
    a = ca;
    b = cb;
    c = cc;
    r.first  = clamp_root(NoRootVal);
    r.second = clamp_root(NoRootVal);
    if (a == 0) begin
      r.status = StAZero;
      return r;
    end
    disc = b * b - 4 * a * c;
    den  = 2 * a;
    nb   = -b * (longint'(1) << FracBits);
    if (disc < 0) begin
      r.status = StNone;
    end else if (disc == 0) begin
      r.first  = clamp_root(nb / den);
      r.second = r.first;
      r.status = StDouble;
    end else begin
      s        = fixed_sqrt(disc);
      r.first  = clamp_root((nb + s) / den);
      r.second = clamp_root((nb - s) / den);
      r.status = StTwo;
    end
    return r;
  endfunction

  function automatic row_t mk_row(input int a, input int b, input int c, input logic known,
                                  input longint f, input longint s, input status_e st);
    row_t r;
    r.a = CoefW'(a);
    r.b = CoefW'(b);
    r.c = CoefW'(c);
    r.known = known;
    r.res.first = RootW'(f);
    r.res.second = RootW'(s);
    r.res.status = st;
    return r;
  endfunction

  // Offer one triple and hold it until the transaction completes
  task automatic send_triple(input logic signed [CoefW-1:0] a,
                             input logic signed [CoefW-1:0] b,
                             input logic signed [CoefW-1:0] c,
                             input roots_t res);
    in_valid <= 1'b1;
    in_data  <= {c, b, a};
    do @(posedge clk); while (!in_ready);
    expected_roots.insert(expected_roots.size(), res);
  endtask

  // Sender: rows, then random triples in bursts with gaps
  initial begin
    int burst;
    int kind;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    rows[0]  = mk_row(0, 0, 0, 1, NoRootVal, NoRootVal, StAZero);
    rows[1]  = mk_row(0, -32768, 32767, 1, NoRootVal, NoRootVal, StAZero);
    rows[2]  = mk_row(1, 0, 1, 1, NoRootVal, NoRootVal, StNone);
    rows[3]  = mk_row(1, 0, 0, 1, 0, 0, StDouble);
    rows[4]  = mk_row(1, -2, 1, 1, 65536, 65536, StDouble);
    rows[5]  = mk_row(1, 0, -1, 1, 65536, -65536, StTwo);
    rows[6]  = mk_row(1, 0, -4, 1, 131072, -131072, StTwo);
    rows[7]  = mk_row(32767, 0, 32767, 1, NoRootVal, NoRootVal, StNone);
    rows[8]  = mk_row(-32768, -32768, -32768, 0, 0, 0, StNone);
    rows[9]  = mk_row(-32768, -32768, 32767, 0, 0, 0, StNone);
    rows[10] = mk_row(32767, 32767, -32768, 0, 0, 0, StNone);
    rows[11] = mk_row(1, -32768, -32768, 0, 0, 0, StNone);
    rows[12] = mk_row(1, 32767, -32768, 0, 0, 0, StNone);
    rows[13] = mk_row(-1, -32768, 32767, 0, 0, 0, StNone);
    rows[14] = mk_row(-32768, 0, 32767, 0, 0, 0, StNone);
    rows[15] = mk_row(3, 7, -11, 0, 0, 0, StNone);
    rows[16] = mk_row(-5, 3, 2, 0, 0, 0, StNone);
    rows[17] = mk_row(4, 4, 1, 0, 0, 0, StNone);
    rows[18] = mk_row(-1, 0, 0, 0, 0, 0, StNone);
    rows[19] = mk_row(2, 1, -32768, 0, 0, 0, StNone);
    in_valid  = 1'b0;
    in_data   = '0;
    stim_done = 1'b0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_triple(rows[i].a, rows[i].b, rows[i].c,
                  rows[i].known ? rows[i].res : solve_roots(rows[i].a, rows[i].b, rows[i].c));
    end
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        kind = $urandom_range(0, 9);
        a = CoefW'($urandom);
        b = CoefW'($urandom);
        c = CoefW'($urandom);
        // Small coefficients for kinds 0 to 3, so all three cases come up often
        if (kind < 4) begin
          a = CoefW'(int'($urandom_range(0, 40)) - 20);
          b = CoefW'(int'($urandom_range(0, 80)) - 40);
          c = CoefW'(int'($urandom_range(0, 40)) - 20);
        end else if (kind == 4) begin
          // Perfect square: double root
          a = CoefW'($urandom_range(1, 90));
          c = a;
          b = CoefW'((($urandom_range(0, 1) != 0) ? 2 : -2) * int'(a));
        end else if (kind == 5) begin
          a = '0;
        end
        send_triple(a, b, c, solve_roots(a, b, c));
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b0;
    stim_done <= 1'b1;
  end

  // Long hold-off once, so the pipeline fills and stalls the input
  initial begin
    long_hold = 1'b0;
    wait (rst_n);
    repeat (400) @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Receiver: stall at random, with stretches of full acceptance
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (long_hold) out_ready <= 1'b0;
      else if ((phase / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result transaction with the oldest expected roots
  always @(posedge clk) begin
    roots_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h / %0d", out_data, out_user);
      end else begin
        exp_r = expected_roots.pop_front();
        if (out_data[33:0] !== exp_r.first || out_data[67:34] !== exp_r.second ||
            out_user !== exp_r.status || out_data[71:68] !== 4'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d (pad %h)",
                     exp_r.first, exp_r.second, exp_r.status,
                     $signed(out_data[33:0]), $signed(out_data[67:34]), out_user,
                     out_data[71:68]);
        end
      end
    end
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
